// ===== rtl/core/rle_nibble_sprite_row_decoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// rle sprite decoder assertion macros
// assertion shorthands for the sprite row decoder controller
// ----------------------------------------------------------------------------
`ifndef RLE_NIBBLE_SPRITE_ROW_DECODER_UNIT_MACROS_SVH
`define RLE_NIBBLE_SPRITE_ROW_DECODER_UNIT_MACROS_SVH

// generic clocked assertion, disabled while the active-low reset is low
`define RLESPRITE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define RLESPRITE_ASSERT_AR(lbl, prop, msg) \
    `RLESPRITE_ASSERT(lbl, aclk, aresetn, prop, msg)

`endif

// ===== rtl/core/rlesprite_pkg.sv =====
// ----------------------------------------------------------------------------
// rlesprite_pkg
// shared types, constants and palette lookup for the sprite row decoder
// ----------------------------------------------------------------------------
package rlesprite_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CEL_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEL_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSP_CLR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_EN   = 2'd3;

    // field widths
    localparam int COL_W    = 10;
    localparam int ROW_W    = 8;
    localparam int CLR_W    = 4;
    localparam int RUN_W    = 5;

    // palette component levels
    localparam logic [7:0] LVL_0 = 8'h00;
    localparam logic [7:0] LVL_L = 8'h55;
    localparam logic [7:0] LVL_M = 8'hAA;
    localparam logic [7:0] LVL_H = 8'hFF;

    // commands from controller to datapath
    typedef struct packed {
        logic start_run;
        logic row_end;
        logic emit;
    } rlesprite_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_end_of_row;
        logic in_count_nz;
        logic out_free;
        logic run_last;
        logic remain_nz;
    } rlesprite_sts_t;

    // fixed 16-entry ega palette, {red, green, blue}
    function automatic logic [23:0] ega_rgb(input logic [CLR_W-1:0] clr);
        logic [23:0] rgb;
        case (clr)
            4'd0:    rgb = {LVL_0, LVL_0, LVL_0};
            4'd1:    rgb = {LVL_0, LVL_0, LVL_M};
            4'd2:    rgb = {LVL_0, LVL_M, LVL_0};
            4'd3:    rgb = {LVL_0, LVL_M, LVL_M};
            4'd4:    rgb = {LVL_M, LVL_0, LVL_0};
            4'd5:    rgb = {LVL_M, LVL_0, LVL_M};
            4'd6:    rgb = {LVL_M, LVL_L, LVL_0};
            4'd7:    rgb = {LVL_M, LVL_M, LVL_M};
            4'd8:    rgb = {LVL_L, LVL_L, LVL_L};
            4'd9:    rgb = {LVL_L, LVL_L, LVL_H};
            4'd10:   rgb = {LVL_L, LVL_H, LVL_L};
            4'd11:   rgb = {LVL_L, LVL_H, LVL_H};
            4'd12:   rgb = {LVL_H, LVL_L, LVL_L};
            4'd13:   rgb = {LVL_H, LVL_L, LVL_H};
            4'd14:   rgb = {LVL_H, LVL_H, LVL_L};
            4'd15:   rgb = {LVL_H, LVL_H, LVL_H};
            default: rgb = {LVL_0, LVL_0, LVL_0};
        endcase
        return rgb;
    endfunction

endpackage

// ===== rtl/core/rle_nibble_sprite_row_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// rle_nibble_sprite_row_decoder_unit
// run-length sprite row decoder, one column of a double-wide pixel per output transfer
//
//   channel  dir  handshake            payload
//   s_       in   s_valid / s_ready    s_rle_byte
//   m_       out  m_valid / m_ready    pixel_x, pixel_y, rgb, opaque, inside, last
//   cfg_     in   cfg_wr_en            cfg_addr, cfg_wdata
//
// a run byte of count n is taken, then its 2n columns go one per cycle from the
// run counter into the single output register while that register is free
// an end-of-row byte or a zero-count byte is taken and gives no pixel
// a pixel waiting with m_ready low holds the output register and stalls the run
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module rle_nibble_sprite_row_decoder_unit
    import rlesprite_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rle_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [9:0]     m_pixel_x,
    output logic [7:0]            m_pixel_y,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    output logic                  m_opaque,
    output logic                  m_inside_res,
    output logic                  m_last
);

    rlesprite_cmd_t cmd;
    rlesprite_sts_t status;

    // run sequencing
    rlesprite_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // counters, palette and output register
    rlesprite_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_rle_byte   (s_rle_byte),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_opaque     (m_opaque),
        .m_inside_res (m_inside_res),
        .m_last       (m_last)
    );

endmodule

// ===== rtl/core/rlesprite_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlesprite_ctrl
// controller: takes run bytes and sequences the pixels of each run
// ----------------------------------------------------------------------------
`include "rle_nibble_sprite_row_decoder_unit_macros.svh"

module rlesprite_ctrl
    import rlesprite_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rlesprite_sts_t status,
    output rlesprite_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   run_done;

    // input side only open between runs
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // commands
    always_comb begin
        cmd.start_run = accept && status.in_count_nz;
        cmd.row_end   = accept && status.in_end_of_row;
        cmd.emit      = (state_reg == ST_RUN) && status.out_free;
    end

    // final pixel of the run is loaded into the output register this cycle
    assign run_done = cmd.emit && status.run_last;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start_run) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RLESPRITE_ASSERT_AR(a_last_ends_run, run_done |=> state_reg == ST_IDLE, "run overran")
    `RLESPRITE_ASSERT_AR(a_run_has_pixels, state_reg == ST_RUN |-> status.remain_nz, "empty run")
    `RLESPRITE_ASSERT_AR(a_start_enters_run, cmd.start_run |=> state_reg == ST_RUN, "no run")

endmodule

// ===== rtl/core/rlesprite_dp.sv =====
// ----------------------------------------------------------------------------
// rlesprite_dp
// datapath: config registers, column and row counters, run counter, output
// ----------------------------------------------------------------------------
module rlesprite_dp
    import rlesprite_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [7:0]            s_rle_byte,
    input  rlesprite_cmd_t        cmd,
    output rlesprite_sts_t        status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [9:0]     m_pixel_x,
    output logic [7:0]            m_pixel_y,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    output logic                  m_opaque,
    output logic                  m_inside_res,
    output logic                  m_last
);

    // configuration
    logic [7:0]       cel_width_reg;
    logic [7:0]       cel_height_reg;
    logic [CLR_W-1:0] transp_reg;
    logic             mirror_reg;

    // decode state
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             fresh_reg, fresh_next;
    logic [RUN_W-1:0] remain_reg, remain_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic             out_valid_reg, out_valid_next;

    // output payload
    logic signed [COL_W-1:0] pix_x_reg;
    logic [ROW_W-1:0]        pix_y_reg;
    logic [23:0]             rgb_reg;
    logic                    opaque_reg;
    logic                    inside_reg;
    logic                    last_reg;

    logic [COL_W-1:0] dbl_width;
    logic [COL_W-1:0] row_start;
    logic [COL_W-1:0] col_step;
    logic [ROW_W:0]   row_inc;
    logic             is_opaque;
    logic             run_last;

    // doubled width and row start column
    assign dbl_width = {1'b0, cel_width_reg, 1'b0};
    assign row_start = mirror_reg ? (dbl_width - COL_W'(1)) : '0;
    assign col_step  = mirror_reg ? (col_reg - COL_W'(1)) : (col_reg + COL_W'(1));
    assign row_inc   = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign is_opaque = (clr_reg != transp_reg);
    assign run_last  = (remain_reg == RUN_W'(1));

    // status
    always_comb begin
        status.in_end_of_row = (s_rle_byte == 8'd0);
        status.in_count_nz   = (s_rle_byte[3:0] != 4'd0);
        status.out_free      = !out_valid_reg || m_ready;
        status.run_last      = run_last;
        status.remain_nz     = (remain_reg != '0);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cel_width_reg  <= '0;
            cel_height_reg <= '0;
            transp_reg     <= '0;
            mirror_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_CEL_WIDTH:  cel_width_reg  <= cfg_wdata;
                CFG_CEL_HEIGHT: cel_height_reg <= cfg_wdata;
                CFG_TRANSP_CLR: transp_reg     <= cfg_wdata[CLR_W-1:0];
                CFG_MIRROR_EN:  mirror_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // counters and run control
    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        fresh_next     = fresh_reg;
        remain_next    = remain_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (cmd.row_end) begin
            row_next   = (row_inc >= {1'b0, cel_height_reg}) ? '0 : row_inc[ROW_W-1:0];
            fresh_next = 1'b1;
        end
        if (cmd.start_run) begin
            if (fresh_reg) begin
                col_next = row_start;
            end
            fresh_next  = 1'b0;
            remain_next = {1'b0, s_rle_byte[3:0]} << 1;
            clr_next    = s_rle_byte[7:4];
        end
        if (cmd.emit) begin
            col_next       = col_step;
            remain_next    = remain_reg - RUN_W'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            fresh_reg     <= 1'b1;
            remain_reg    <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            fresh_reg     <= fresh_next;
            remain_reg    <= remain_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output pixel register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            pix_x_reg  <= col_reg;
            pix_y_reg  <= row_reg;
            rgb_reg    <= is_opaque ? ega_rgb(clr_reg) : '0;
            opaque_reg <= is_opaque;
            inside_reg <= !col_reg[COL_W-1] && (col_reg < dbl_width);
            last_reg   <= run_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_pixel_x    = pix_x_reg;
    assign m_pixel_y    = pix_y_reg;
    assign m_red        = rgb_reg[23:16];
    assign m_green      = rgb_reg[15:8];
    assign m_blue       = rgb_reg[7:0];
    assign m_opaque     = opaque_reg;
    assign m_inside_res = inside_reg;
    assign m_last       = last_reg;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: run-length sprite row decoder testbench
// run bytes go in through a queue-fed driver; every accepted byte is decoded
// by a local pixel predictor, and a monitor compares each pixel transfer
// with the oldest predicted pixel. random idling on both channels, a long
// receiver hold-off, and register changes between quiet phases.
// ----------------------------------------------------------------------------
module tb_top
    import rlesprite_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    // fixed ega palette, {red, green, blue}
    localparam logic [23:0] EGA_PAL [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef struct packed {
        logic [9:0] col;
        logic [7:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       opaque;
        logic       in_cel;
        logic       last;
    } pixel_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rle_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic signed [9:0]     m_pixel_x;
    logic [7:0]            m_pixel_y;
    logic [7:0]            m_red;
    logic [7:0]            m_green;
    logic [7:0]            m_blue;
    logic                  m_opaque;
    logic                  m_inside_res;
    logic                  m_last;

    // register shadows and decoder state as the predictor sees them
    logic [7:0] cel_width_sh   = 8'd0;
    logic [7:0] cel_height_sh  = 8'd0;
    logic [3:0] transp_clr_sh  = 4'd0;
    logic       mirror_sh      = 1'b0;
    logic [9:0] col_pos        = 10'd0;
    logic [7:0] row_idx        = 8'd0;
    logic       row_fresh      = 1'b1;

    logic [7:0] rle_byte_q [$];
    pixel_t     pixel_expect_q [$];

    int  fail_cnt     = 0;
    int  idle_mode    = 0;
    int  src_gap      = 0;
    int  snk_gap      = 0;
    int  hold_cnt     = 0;
    bit  hold_req     = 1'b0;
    int  stall_cycles = 0;

    rle_nibble_sprite_row_decoder_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rle_byte   (s_rle_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_opaque     (m_opaque),
        .m_inside_res (m_inside_res),
        .m_last       (m_last)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic note_failure(input string msg);
        if (fail_cnt < MAX_REPORTS) $display("%s", msg);
        fail_cnt++;
    endtask

    // decode one run byte into the doubled pixels it should produce
    task automatic decode_run_byte(input logic [7:0] rb);
        logic [3:0]  clr;
        logic [3:0]  cnt;
        logic [23:0] rgb;
        logic        opq;
        logic [8:0]  nxt_row;
        logic [10:0] dbl_w;
        int          total;
        pixel_t      px;
        // end of row: advance the row, wrap at the cel height
        if (rb == 8'h00) begin
            nxt_row = {1'b0, row_idx} + 9'd1;
            row_idx = (nxt_row >= {1'b0, cel_height_sh}) ? 8'd0 : nxt_row[7:0];
            row_fresh = 1'b1;
            return;
        end
        clr = rb[7:4];
        cnt = rb[3:0];
        // zero count changes nothing
        if (cnt == 4'd0) return;
        dbl_w = {2'b00, cel_width_sh, 1'b0};
        // first run of a row loads the start column from current registers
        if (row_fresh) begin
            col_pos = mirror_sh ? (dbl_w[9:0] - 10'd1) : 10'd0;
            row_fresh = 1'b0;
        end
        if (clr != transp_clr_sh) begin
            rgb = EGA_PAL[clr];
            opq = 1'b1;
        end else begin
            rgb = 24'h000000;
            opq = 1'b0;
        end
        total = 2 * int'(cnt);
        for (int k = 0; k < total; k++) begin
            px.col    = col_pos;
            px.row    = row_idx;
            {px.red, px.green, px.blue} = rgb;
            px.opaque = opq;
            px.in_cel = !col_pos[9] && ({1'b0, col_pos} < dbl_w);
            px.last   = (k == total - 1);
            pixel_expect_q.push_back(px);
            col_pos = mirror_sh ? (col_pos - 10'd1) : (col_pos + 10'd1);
        end
    endtask

    // input driver: offers queued bytes, predicts on each accepted transfer
    always @(posedge aclk) begin : byte_driver
        logic       nxt_valid;
        logic [7:0] nxt_byte;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            nxt_valid = s_valid;
            nxt_byte  = s_rle_byte;
            if (s_valid && s_ready) begin
                decode_run_byte(s_rle_byte);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (rle_byte_q.size() > 0) begin
                    if (idle_mode != 0 && $urandom_range(0, 15) < 2 * idle_mode) begin
                        src_gap = $urandom_range(0, 7);
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_byte  = rle_byte_q.pop_front();
                    end
                end
            end
            s_valid    <= nxt_valid;
            s_rle_byte <= nxt_byte;
        end
    end

    // pixel monitor and receiver back-pressure
    always @(posedge aclk) begin : pixel_monitor
        pixel_t got;
        pixel_t want;
        logic   nxt_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_pixel_x, m_pixel_y, m_red, m_green, m_blue,
                        m_opaque, m_inside_res, m_last};
                if (pixel_expect_q.size() == 0) begin
                    note_failure($sformatf("unexpected pixel: col %0d row %0d",
                                           $signed(got.col), got.row));
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (got !== want)
                        note_failure($sformatf({"pixel mismatch: expected col %0d row %0d ",
                            "rgb %h%h%h opaque %b inside %b last %b, got col %0d row %0d ",
                            "rgb %h%h%h opaque %b inside %b last %b"},
                            $signed(want.col), want.row, want.red, want.green, want.blue,
                            want.opaque, want.in_cel, want.last,
                            $signed(got.col), got.row, got.red, got.green, got.blue,
                            got.opaque, got.in_cel, got.last));
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                nxt_ready = 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = LONG_HOLD;
                nxt_ready = 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                nxt_ready = 1'b0;
            end else if (idle_mode != 0 && $urandom_range(0, 15) < 2 * idle_mode) begin
                snk_gap = $urandom_range(0, 7);
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_ready <= nxt_ready;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // wait until every byte is taken and every pixel seen, then settle
    task automatic wait_quiet();
        do @(negedge aclk);
        while (rle_byte_q.size() != 0 || s_valid || pixel_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CEL_WIDTH:  cel_width_sh  = val;
            CFG_CEL_HEIGHT: cel_height_sh = val;
            CFG_TRANSP_CLR: transp_clr_sh = val[3:0];
            CFG_MIRROR_EN:  mirror_sh     = val[0];
            default: ;
        endcase
    endtask

    // all four registers; upper data bits of the narrow ones are random
    task automatic configure(input logic [7:0] w, input logic [7:0] h,
                             input logic [3:0] t, input logic m);
        write_reg(CFG_CEL_WIDTH, w);
        write_reg(CFG_CEL_HEIGHT, h);
        write_reg(CFG_TRANSP_CLR, {4'($urandom), t});
        write_reg(CFG_MIRROR_EN, {7'($urandom), m});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // well-formed rows with random content, plus stray and zero-count bytes
    task automatic queue_rows(input int n_items, input int max_runs, input bit long_runs);
        int         n;
        int         runs;
        int         pick;
        logic [7:0] rb;
        n = 0;
        while (n < n_items) begin
            runs = $urandom_range(1, max_runs);
            for (int r = 0; r < runs && n < n_items; r++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    rb = 8'($urandom);
                end else if (pick == 1) begin
                    rb = {4'($urandom), 4'h0};
                end else begin
                    rb[7:4] = 4'($urandom);
                    rb[3:0] = long_runs ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(1, 15));
                end
                rle_byte_q.push_back(rb);
                if (rb == 8'h00 || rb[3:0] != 4'h0) n++;
            end
            if (n < n_items && $urandom_range(0, 9) != 0) begin
                rle_byte_q.push_back(8'h00);
                n++;
            end
            // occasional empty row
            if (n < n_items && $urandom_range(0, 7) == 0) begin
                rle_byte_q.push_back(8'h00);
                n++;
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] w;
        logic [7:0] h;
        logic [3:0] t;
        logic       m;
        int         max_runs;
        bit         long_runs;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // registers at reset: zero width and zero height
        idle_mode = 1;
        rle_byte_q.push_back(8'h11);
        rle_byte_q.push_back(8'h00);
        wait_quiet();

        // every colour, transparent one included, then the widest run
        configure(8'd8, 8'd3, 4'd5, 1'b0);
        for (int c = 0; c < 16; c++) rle_byte_q.push_back({4'(c), 4'h1});
        rle_byte_q.push_back(8'h50);
        rle_byte_q.push_back(8'h00);
        rle_byte_q.push_back(8'hFF);
        rle_byte_q.push_back(8'h00);
        wait_quiet();

        // zero width mirrored starts left of the cel
        configure(8'd0, 8'd255, 4'd15, 1'b1);
        rle_byte_q.push_back(8'h32);
        rle_byte_q.push_back(8'h00);
        wait_quiet();

        // random phases, register extremes first, quiet last phase
        for (int p = 0; p < 8; p++) begin
            max_runs  = 8;
            long_runs = 1'b0;
            t = 4'($urandom);
            m = 1'($urandom);
            case (p)
                0: begin
                    w = 8'd255; h = 8'd255; t = 4'd15; m = 1'b0;
                    max_runs = 40; long_runs = 1'b1;
                end
                1: begin
                    w = 8'd255; h = 8'd1; t = 4'd0; m = 1'b1;
                    max_runs = 40; long_runs = 1'b1;
                end
                2: begin
                    w = 8'd0; h = 8'd0; max_runs = 6;
                end
                default: begin
                    w = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(1, 24));
                    h = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 6))
                                                    : 8'($urandom_range(0, 255));
                end
            endcase
            wait_quiet();
            idle_mode = (p == 7) ? 0 : $urandom_range(0, 2);
            configure(w, h, t, m);
            queue_rows(57, max_runs, long_runs);
            // receiver stalls long enough to back the block up
            if (p == 0) hold_req = 1'b1;
        end
        wait_quiet();

        if (pixel_expect_q.size() != 0)
            note_failure($sformatf("%0d expected pixels never arrived",
                                   pixel_expect_q.size()));
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
